@@ design/dacplc_pkg.sv @@
package dacplc_pkg;

  localparam int unsigned NUM_CHANNELS = 3;
  localparam int unsigned NUM_POINTS   = 13;
  localparam int unsigned MEM_DEPTH    = NUM_CHANNELS * NUM_POINTS;
  localparam int unsigned ADDR_W       = $clog2(MEM_DEPTH);

  localparam int unsigned CODE_W  = 12;
  localparam int unsigned MV_W    = 13;
  localparam int unsigned ENTRY_W = CODE_W + MV_W;

  localparam logic [CODE_W-1:0] CODE_MAX      = 12'd4095;
  localparam logic [MV_W-1:0]   TARGET_MAX_MV = 13'd5000;

  localparam logic [3:0] DIV_LAST = 4'd13;

  localparam int unsigned UPC_W = 4;

  localparam logic [UPC_W-1:0] UPC_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] UPC_DISPATCH = 4'd1;
  localparam logic [UPC_W-1:0] UPC_RD_FIRST = 4'd2;
  localparam logic [UPC_W-1:0] UPC_SEARCH   = 4'd3;
  localparam logic [UPC_W-1:0] UPC_RD_LO    = 4'd4;
  localparam logic [UPC_W-1:0] UPC_LATCH_LO = 4'd5;
  localparam logic [UPC_W-1:0] UPC_DIFF     = 4'd6;
  localparam logic [UPC_W-1:0] UPC_MUL      = 4'd7;
  localparam logic [UPC_W-1:0] UPC_DIV_INIT = 4'd8;
  localparam logic [UPC_W-1:0] UPC_DIV_STEP = 4'd9;
  localparam logic [UPC_W-1:0] UPC_FINISH   = 4'd10;
  localparam logic [UPC_W-1:0] UPC_ZERO     = 4'd11;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_RD_FIRST,
    ACT_SEARCH,
    ACT_RD_LO,
    ACT_LATCH_LO,
    ACT_DIFF,
    ACT_MUL,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_FINISH,
    ACT_ZERO
  } act_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_LOAD_OR_BAD,
    COND_NOT_FOUND,
    COND_DEN_ZERO,
    COND_DIV_MORE
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    case (upc)
      UPC_IDLE:     w = '{act: ACT_NONE,     cond: COND_NO_START,    target: UPC_IDLE};
      UPC_DISPATCH: w = '{act: ACT_NONE,     cond: COND_LOAD_OR_BAD, target: UPC_ZERO};
      UPC_RD_FIRST: w = '{act: ACT_RD_FIRST, cond: COND_NEVER,       target: UPC_IDLE};
      UPC_SEARCH:   w = '{act: ACT_SEARCH,   cond: COND_NOT_FOUND,   target: UPC_SEARCH};
      UPC_RD_LO:    w = '{act: ACT_RD_LO,    cond: COND_NEVER,       target: UPC_IDLE};
      UPC_LATCH_LO: w = '{act: ACT_LATCH_LO, cond: COND_NEVER,       target: UPC_IDLE};
      UPC_DIFF:     w = '{act: ACT_DIFF,     cond: COND_DEN_ZERO,    target: UPC_FINISH};
      UPC_MUL:      w = '{act: ACT_MUL,      cond: COND_NEVER,       target: UPC_IDLE};
      UPC_DIV_INIT: w = '{act: ACT_DIV_INIT, cond: COND_NEVER,       target: UPC_IDLE};
      UPC_DIV_STEP: w = '{act: ACT_DIV_STEP, cond: COND_DIV_MORE,    target: UPC_DIV_STEP};
      UPC_FINISH:   w = '{act: ACT_FINISH,   cond: COND_ALWAYS,      target: UPC_IDLE};
      UPC_ZERO:     w = '{act: ACT_ZERO,     cond: COND_ALWAYS,      target: UPC_IDLE};
      default:      w = '{act: ACT_NONE,     cond: COND_ALWAYS,      target: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ design/dacplc_ram.sv @@
module dacplc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/dac_piecewise_linear_calibration_core.sv @@
// A transaction is accepted on a clock edge with start high and busy low; every transaction
// returns exactly one result, shown on dac_code_o, segment_o and saturated_o for the single
// cycle in which done_o is high, so the receiver must capture it in that cycle. A load, and a
// convert on an unknown channel, pass from dispatch straight to the zero-result step. A convert
// is busy through the segment search, which reads one breakpoint per cycle through the single
// read port of the table memory, and through the radix-4 divider, which forms the rounded
// quotient; when the segment has a zero voltage span, the multiply and divide are skipped.
// The result strobe rises at the clock edge at which busy falls, and the next transaction may
// be accepted in that cycle.
module dac_piecewise_linear_calibration_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [1:0]         channel_i,
  input  logic [3:0]         point_index_i,
  input  logic [11:0]        point_code_i,
  input  logic [12:0]        point_mv_i,
  input  logic signed [15:0] target_mv_i,
  output logic [11:0]        dac_code_o,
  output logic [3:0]         segment_o,
  output logic               saturated_o,
  output logic               done_o
);

  localparam int unsigned AW = dacplc_pkg::ADDR_W;

  logic [dacplc_pkg::UPC_W-1:0] upc_q, upc_d;
  dacplc_pkg::ucode_t           uword;
  logic                         accept;
  logic                         cond_hit;

  logic        op_q;
  logic [1:0]  ch_q;
  logic [3:0]  slot_q;
  logic [11:0] pcode_q;
  logic [12:0] pmv_q;
  logic [12:0] t_q, t_d;

  logic [3:0]  seg_q, seg_d;
  logic [11:0] c0_q, c0_d, c1_q, c1_d;
  logic [12:0] v0_q, v0_d, v1_q, v1_d;
  logic signed [12:0] dc_q, dc_d;
  logic signed [13:0] dv_q, dv_d;
  logic [12:0] den_q, den_d;
  logic signed [26:0] num_q, num_d;
  logic        neg_q, neg_d;
  logic [27:0] dvd_q, dvd_d;
  logic [13:0] rem_q, rem_d;
  logic [3:0]  cnt_q, cnt_d;

  logic [11:0] dac_code_q, dac_code_d;
  logic [3:0]  segment_q, segment_d;
  logic        saturated_q, saturated_d;
  logic        done_q, done_d;

  logic          ch_ok, slot_ok, seg_last, found;
  logic [AW-1:0] base, seg_a;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [dacplc_pkg::ENTRY_W-1:0] ram_rdata;
  logic [11:0]   rd_code;
  logic [12:0]   rd_mv;

  logic [13:0] den_full, dv_full;
  logic [12:0] dc_full;
  logic        den_neg, den_zero;
  logic [27:0] x_full;
  logic [13:0] dsr;
  logic [13:0] div_rem;
  logic [27:0] div_dvd;
  logic [28:0] q_full;
  logic [29:0] val_full;

  assign busy   = (upc_q != dacplc_pkg::UPC_IDLE);
  assign accept = start && !busy;
  assign uword  = dacplc_pkg::ucode_rom(upc_q);

  assign ch_ok    = (32'(ch_q) < dacplc_pkg::NUM_CHANNELS);
  assign slot_ok  = (32'(slot_q) < dacplc_pkg::NUM_POINTS);
  assign seg_last = (32'(seg_q) == dacplc_pkg::NUM_POINTS - 2);
  assign rd_code  = ram_rdata[dacplc_pkg::MV_W +: dacplc_pkg::CODE_W];
  assign rd_mv    = ram_rdata[0 +: dacplc_pkg::MV_W];
  assign found    = (t_q < rd_mv) || seg_last;

  assign base  = AW'(ch_q) * AW'(dacplc_pkg::NUM_POINTS);
  assign seg_a = AW'(seg_q);

  assign den_full = {1'b0, v1_q} - {1'b0, v0_q};
  assign dv_full  = {1'b0, t_q} - {1'b0, v0_q};
  assign dc_full  = {1'b0, c1_q} - {1'b0, c0_q};
  assign den_neg  = den_full[13];
  assign den_zero = (den_full == 14'd0);

  assign x_full = {num_q, 1'b0} + {15'd0, den_q};
  assign dsr    = {den_q, 1'b0};

  assign q_full   = neg_q ? ~{1'b0, dvd_q} : {1'b0, dvd_q};
  assign val_full = {18'd0, c0_q} + {q_full[28], q_full};

  always_comb begin
    logic [14:0] trial;
    div_rem = rem_q;
    div_dvd = dvd_q;
    for (int i = 0; i < 2; i++) begin
      trial   = {div_rem, div_dvd[27]};
      div_dvd = {div_dvd[26:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        div_rem    = 14'(trial - {1'b0, dsr});
        div_dvd[0] = 1'b1;
      end else begin
        div_rem = trial[13:0];
      end
    end
  end

  always_comb begin
    case (uword.cond)
      dacplc_pkg::COND_NEVER:       cond_hit = 1'b0;
      dacplc_pkg::COND_ALWAYS:      cond_hit = 1'b1;
      dacplc_pkg::COND_NO_START:    cond_hit = !start;
      dacplc_pkg::COND_LOAD_OR_BAD: cond_hit = op_q || !ch_ok;
      dacplc_pkg::COND_NOT_FOUND:   cond_hit = !found;
      dacplc_pkg::COND_DEN_ZERO:    cond_hit = den_zero;
      dacplc_pkg::COND_DIV_MORE:    cond_hit = (cnt_q != dacplc_pkg::DIV_LAST);
      default:                      cond_hit = 1'b0;
    endcase
    upc_d = cond_hit ? uword.target : upc_q + 4'd1;
  end

  always_comb begin
    t_d         = t_q;
    seg_d       = seg_q;
    c0_d        = c0_q;
    c1_d        = c1_q;
    v0_d        = v0_q;
    v1_d        = v1_q;
    dc_d        = dc_q;
    dv_d        = dv_q;
    den_d       = den_q;
    num_d       = num_q;
    neg_d       = neg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    dac_code_d  = dac_code_q;
    segment_d   = segment_q;
    saturated_d = saturated_q;
    done_d      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = base + seg_a;
    ram_waddr   = base + AW'(slot_q);

    if (accept) begin
      seg_d = 4'd0;
      if (target_mv_i[15]) begin
        t_d = 13'd0;
      end else if (target_mv_i > $signed({3'b000, dacplc_pkg::TARGET_MAX_MV})) begin
        t_d = dacplc_pkg::TARGET_MAX_MV;
      end else begin
        t_d = target_mv_i[12:0];
      end
    end

    case (uword.act)
      dacplc_pkg::ACT_NONE: begin
      end
      dacplc_pkg::ACT_RD_FIRST: begin
        ram_re    = 1'b1;
        ram_raddr = base + seg_a + AW'(1);
      end
      dacplc_pkg::ACT_SEARCH: begin
        c1_d = rd_code;
        v1_d = rd_mv;
        if (!found) begin
          seg_d     = seg_q + 4'd1;
          ram_re    = 1'b1;
          ram_raddr = base + seg_a + AW'(2);
        end
      end
      dacplc_pkg::ACT_RD_LO: begin
        ram_re = 1'b1;
      end
      dacplc_pkg::ACT_LATCH_LO: begin
        c0_d = rd_code;
        v0_d = rd_mv;
      end
      dacplc_pkg::ACT_DIFF: begin
        dc_d  = dc_full;
        den_d = den_neg ? 13'(-den_full) : den_full[12:0];
        dv_d  = den_neg ? -dv_full : dv_full;
        neg_d = 1'b0;
        dvd_d = 28'd0;
      end
      dacplc_pkg::ACT_MUL: begin
        num_d = dc_q * dv_q;
      end
      dacplc_pkg::ACT_DIV_INIT: begin
        neg_d = x_full[27];
        dvd_d = x_full[27] ? ~x_full : x_full;
        rem_d = 14'd0;
        cnt_d = 4'd0;
      end
      dacplc_pkg::ACT_DIV_STEP: begin
        dvd_d = div_dvd;
        rem_d = div_rem;
        cnt_d = cnt_q + 4'd1;
      end
      dacplc_pkg::ACT_FINISH: begin
        done_d    = 1'b1;
        segment_d = seg_q;
        if (val_full[29]) begin
          dac_code_d  = 12'd0;
          saturated_d = 1'b1;
        end else if (val_full[28:0] > {17'd0, dacplc_pkg::CODE_MAX}) begin
          dac_code_d  = dacplc_pkg::CODE_MAX;
          saturated_d = 1'b1;
        end else begin
          dac_code_d  = val_full[11:0];
          saturated_d = 1'b0;
        end
      end
      dacplc_pkg::ACT_ZERO: begin
        done_d      = 1'b1;
        dac_code_d  = 12'd0;
        segment_d   = 4'd0;
        saturated_d = 1'b0;
        ram_we      = op_q && ch_ok && slot_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= dacplc_pkg::UPC_IDLE;
      cnt_q       <= 4'd0;
      done_q      <= 1'b0;
      dac_code_q  <= 12'd0;
      segment_q   <= 4'd0;
      saturated_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
      dac_code_q  <= dac_code_d;
      segment_q   <= segment_d;
      saturated_q <= saturated_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      ch_q    <= channel_i;
      slot_q  <= point_index_i;
      pcode_q <= point_code_i;
      pmv_q   <= point_mv_i;
    end
    t_q   <= t_d;
    seg_q <= seg_d;
    c0_q  <= c0_d;
    c1_q  <= c1_d;
    v0_q  <= v0_d;
    v1_q  <= v1_d;
    dc_q  <= dc_d;
    dv_q  <= dv_d;
    den_q <= den_d;
    num_q <= num_d;
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  dacplc_ram #(
    .WIDTH(dacplc_pkg::ENTRY_W),
    .DEPTH(dacplc_pkg::MEM_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({pcode_q, pmv_q}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign dac_code_o  = dac_code_q;
  assign segment_o   = segment_q;
  assign saturated_o = saturated_q;
  assign done_o      = done_q;

endmodule
